[rtl/core/sitda_pkg.sv]
// Shared types, constants and microprogram for the signed integer to decimal ASCII converter.
package sitda_pkg;

  localparam int NUM_W   = 32;
  localparam int CHAR_W  = 8;
  localparam int DEC_W   = 4;
  localparam int DIGIT_W = 4;
  localparam int UPC_W   = 2;

  localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'd48;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX   = 4'd9;
  localparam logic [DEC_W-1:0]   UNITS_DEC   = 4'd9;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [3:0] {
    OP_WAIT_IN = 4'b0001,
    OP_SIGN    = 4'b0010,
    OP_SUB     = 4'b0100,
    OP_DIGIT   = 4'b1000
  } op_t;

  typedef enum logic [1:0] {
    C_ALWAYS,
    C_ACCEPT,
    C_CAN_SUB,
    C_MORE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  tgt;
    upc_t  alt;
  } uword_t;

  typedef struct packed {
    logic accept;
    logic can_sub;
    logic more;
    logic hold;
  } status_t;

  localparam upc_t UPC_IDLE  = 2'd0;
  localparam upc_t UPC_SIGN  = 2'd1;
  localparam upc_t UPC_SUB   = 2'd2;
  localparam upc_t UPC_DIGIT = 2'd3;

  // next = cond ? tgt : alt
  function automatic uword_t ucode(input upc_t addr);
    uword_t w;
    case (addr)
      UPC_IDLE:  w = '{op: OP_WAIT_IN, cond: C_ACCEPT,  tgt: UPC_SIGN, alt: UPC_IDLE};
      UPC_SIGN:  w = '{op: OP_SIGN,    cond: C_ALWAYS,  tgt: UPC_SUB,  alt: UPC_SUB};
      UPC_SUB:   w = '{op: OP_SUB,     cond: C_CAN_SUB, tgt: UPC_SUB,  alt: UPC_DIGIT};
      UPC_DIGIT: w = '{op: OP_DIGIT,   cond: C_MORE,    tgt: UPC_SUB,  alt: UPC_IDLE};
      default:   w = '{op: OP_WAIT_IN, cond: C_ALWAYS,  tgt: UPC_IDLE, alt: UPC_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [NUM_W-1:0] decade_weight(input logic [DEC_W-1:0] d);
    logic [NUM_W-1:0] w;
    case (d)
      4'd0:    w = 32'd1000000000;
      4'd1:    w = 32'd100000000;
      4'd2:    w = 32'd10000000;
      4'd3:    w = 32'd1000000;
      4'd4:    w = 32'd100000;
      4'd5:    w = 32'd10000;
      4'd6:    w = 32'd1000;
      4'd7:    w = 32'd100;
      4'd8:    w = 32'd10;
      default: w = 32'd1;
    endcase
    return w;
  endfunction

endpackage

[rtl/core/sitda_if.sv]
// Request channel interfaces: number in, characters out.
interface sitda_num_if;
  logic                               valid;
  logic                               ready;
  logic signed [sitda_pkg::NUM_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface sitda_char_if;
  logic                         valid;
  logic                         ready;
  logic [sitda_pkg::CHAR_W-1:0] ascii_char;
  logic                         last_char;

  modport source (output valid, output ascii_char, output last_char, input ready);
  modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

[rtl/core/signed_int_to_decimal_ascii.sv]
// Top level: signed 32-bit integer to decimal ASCII, microcoded sequencer plus datapath.
// Flow: once a request is accepted the sequencer moves to the sign step, which loads a
//   minus sign into the output register for a negative number, then to the decade loop;
//   the loop does one subtraction per cycle, and output stalls hold the sign and digit
//   steps. A new number is accepted only in the idle step, after the units digit.
// Reset (synchronous): sequencer returns to the idle step, output register empties.
module signed_int_to_decimal_ascii (
  input  logic         clk,
  input  logic         rst,
  sitda_num_if.sink    num,
  sitda_char_if.source text
);

  sitda_pkg::op_t     op;
  sitda_pkg::status_t status;

  sitda_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  sitda_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .status (status),
    .num    (num),
    .text   (text)
  );

endmodule

[rtl/core/sitda_sequencer.sv]
// Microcode sequencer: step counter, control ROM and conditional jump logic.
module sitda_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  sitda_pkg::status_t status,
  output sitda_pkg::op_t     op
);

  sitda_pkg::upc_t   upc;
  sitda_pkg::upc_t   upc_next;
  sitda_pkg::uword_t word;
  logic              taken;

  assign word = sitda_pkg::ucode(upc);
  assign op   = word.op;

  always_comb begin
    unique case (word.cond)
      sitda_pkg::C_ALWAYS:  taken = 1'b1;
      sitda_pkg::C_ACCEPT:  taken = status.accept;
      sitda_pkg::C_CAN_SUB: taken = status.can_sub;
      sitda_pkg::C_MORE:    taken = status.more;
      default:              taken = 1'b1;
    endcase
    if (status.hold) begin
      upc_next = upc;
    end else begin
      upc_next = taken ? word.tgt : word.alt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= sitda_pkg::UPC_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

`ifndef SYNTHESIS
  a_hold_keeps_step: assert property (@(posedge clk) disable iff (rst)
    status.hold |=> (upc == $past(upc)))
    else $error("step advanced while output stalled");
  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    status.accept |-> (upc == sitda_pkg::UPC_IDLE))
    else $error("request accepted outside idle step");
  a_accept_to_sign: assert property (@(posedge clk) disable iff (rst)
    status.accept |=> (upc == sitda_pkg::UPC_SIGN))
    else $error("accepted request did not start conversion");
`endif

endmodule

[rtl/core/sitda_datapath.sv]
// Datapath: magnitude, decade and digit registers, subtractor and output register.
module sitda_datapath (
  input  logic                clk,
  input  logic                rst,
  input  sitda_pkg::op_t      op,
  output sitda_pkg::status_t  status,
  sitda_num_if.sink           num,
  sitda_char_if.source        text
);

  logic                            neg;
  logic [sitda_pkg::NUM_W-1:0]     mag;
  logic [sitda_pkg::DEC_W-1:0]     decade;
  logic [sitda_pkg::DIGIT_W-1:0]   digit;
  logic                            started;
  logic                            out_valid;
  logic [sitda_pkg::CHAR_W-1:0]    out_char;
  logic                            out_last;

  logic [sitda_pkg::NUM_W-1:0]     weight;
  logic                            can_sub;
  logic                            units;
  logic                            emit_req;
  logic                            out_free;
  logic                            hold;
  logic                            accept;

  assign weight   = sitda_pkg::decade_weight(decade);
  assign can_sub  = (mag >= weight) && (digit != sitda_pkg::DIGIT_MAX);
  assign units    = (decade == sitda_pkg::UNITS_DEC);
  assign out_free = !out_valid || text.ready;
  assign num.ready = (op == sitda_pkg::OP_WAIT_IN) && !rst;
  assign accept   = num.valid && num.ready;

  always_comb begin
    unique case (op)
      sitda_pkg::OP_SIGN:  emit_req = neg;
      sitda_pkg::OP_DIGIT: emit_req = (digit != '0) || started || units;
      default:             emit_req = 1'b0;
    endcase
  end

  assign hold = emit_req && !out_free;

  assign status = '{accept: accept, can_sub: can_sub, more: !units, hold: hold};

  assign text.valid      = out_valid;
  assign text.ascii_char = out_char;
  assign text.last_char  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_req && out_free) begin
      out_valid <= 1'b1;
    end else if (text.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_req && out_free) begin
      if (op == sitda_pkg::OP_SIGN) begin
        out_char <= sitda_pkg::ASCII_MINUS;
        out_last <= 1'b0;
      end else begin
        out_char <= sitda_pkg::ASCII_ZERO + {{(sitda_pkg::CHAR_W-sitda_pkg::DIGIT_W){1'b0}}, digit};
        out_last <= units;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      sitda_pkg::OP_WAIT_IN: begin
        if (accept) begin
          neg     <= num.number[sitda_pkg::NUM_W-1];
          // most negative value wraps to its unsigned magnitude
          mag     <= num.number[sitda_pkg::NUM_W-1] ? ('0 - $unsigned(num.number))
                                                    : $unsigned(num.number);
          decade  <= '0;
          digit   <= '0;
          started <= 1'b0;
        end
      end
      sitda_pkg::OP_SUB: begin
        if (can_sub) begin
          mag   <= mag - weight;
          digit <= digit + 1'b1;
        end
      end
      sitda_pkg::OP_DIGIT: begin
        if (!hold) begin
          if (digit != '0) begin
            started <= 1'b1;
          end
          digit <= '0;
          if (!units) begin
            decade <= decade + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_sub_shrinks: assert property (@(posedge clk) disable iff (rst)
    (op == sitda_pkg::OP_SUB && can_sub) |=> (mag < $past(mag)))
    else $error("subtraction did not reduce magnitude");
  a_digit_done: assert property (@(posedge clk) disable iff (rst)
    (op == sitda_pkg::OP_DIGIT) |-> ((mag < weight) || (digit == sitda_pkg::DIGIT_MAX)))
    else $error("digit emitted before decade finished");
  a_sign_out: assert property (@(posedge clk) disable iff (rst)
    (op == sitda_pkg::OP_SIGN && emit_req && out_free) |=>
      (out_valid && out_char == sitda_pkg::ASCII_MINUS && !out_last))
    else $error("minus sign not loaded into output register");
`endif

endmodule
